// ===== src/rbsim_pkg.sv =====
// Shared types and constants for the ring buffer slot index manager.
// Used by rbsim_step and ring_buffer_slot_index_manager_core; depends on nothing.
`default_nettype none

package rbsim_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int GEN_BITS = 8;
  localparam int ST_W     = 2;
  localparam int ENTRY_W  = GEN_BITS + ST_W;
  localparam int POS_W    = 12;
  localparam int CAP_W    = 5;
  localparam int LEN_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 12;

  localparam logic [CAP_W-1:0]    CAP_RESET  = 5'd16;
  localparam logic [GEN_BITS-1:0] LGEN_RESET = 8'd255;
  localparam logic [POS_W-1:0]    LCI_RESET  = 12'd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY  = 2'd0,
    REG_LAST_GEN  = 2'd1,
    REG_LAST_CIDX = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_RSV_PUSH    = 4'd0,
    OP_COMMIT_PUSH = 4'd1,
    OP_RSV_POP     = 4'd2,
    OP_COMMIT_POP  = 4'd3,
    OP_ABORT_PUSH  = 4'd4,
    OP_CLEAR_POP   = 4'd5,
    OP_DISABLE     = 4'd6,
    OP_ENABLE      = 4'd7,
    OP_QUERY       = 4'd8
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_DISABLED  = 3'd3,
    STAT_CLEAR_END = 3'd4,
    STAT_BUSY      = 3'd5
  } status_t;

  typedef enum logic [ST_W-1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_WRITING = 2'd1,
    SLOT_FULL    = 2'd2,
    SLOT_READING = 2'd3
  } slot_state_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [GEN_BITS-1:0] gen;
    logic [SLOT_W-1:0]   slot;
  } pos_t;

  typedef struct packed {
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    pos_t                push_next;
    pos_t                pop_next;
    logic                disabled_next;
    status_t             status;
    logic [GEN_BITS-1:0] ggen;
    logic [SLOT_W-1:0]   gslot;
    logic [LEN_W-1:0]    qlen;
  } step_out_t;

endpackage

`default_nettype wire

// ===== src/ring_buffer_slot_index_manager_core.sv =====
// Top level of the ring buffer slot index manager: control, registers, slot table and output.
// Depends on rbsim_pkg, rbsim_ram and rbsim_step.
`default_nettype none

// Each transaction first does a registered read of the slot table entry under the push or
// pop position, then, once the output register is empty or being drained, updates the entry,
// writes it back and loads the output register; no new transaction is accepted before that.
// The output register lets the next transaction be accepted while a result waits. The slot
// table reads as empty with generation zero right after reset; no clearing pass is needed.
module ring_buffer_slot_index_manager_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [3:0]                          opcode,
  input  wire logic [rbsim_pkg::GEN_BITS-1:0]      generation,
  input  wire logic [rbsim_pkg::SLOT_W-1:0]        slot_index,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               status,
  output logic [rbsim_pkg::GEN_BITS-1:0]           granted_generation,
  output logic [rbsim_pkg::SLOT_W-1:0]             granted_slot,
  output logic [rbsim_pkg::LEN_W-1:0]              queue_length,
  output logic                                     enabled,
  input  wire logic                                cfg_we,
  input  wire logic [rbsim_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rbsim_pkg::CFG_W-1:0]         cfg_data
);

  rbsim_pkg::fsm_t                   state;
  rbsim_pkg::fsm_t                   state_next;
  logic [3:0]                        op_q;
  logic [rbsim_pkg::GEN_BITS-1:0]    gen_q;
  logic [rbsim_pkg::SLOT_W-1:0]      slot_q;
  rbsim_pkg::pos_t                   push;
  rbsim_pkg::pos_t                   pop;
  logic                              disabled;
  logic [rbsim_pkg::CAP_W-1:0]       capacity;
  logic [rbsim_pkg::GEN_BITS-1:0]    last_gen;
  logic [rbsim_pkg::POS_W-1:0]       last_cidx;
  logic [rbsim_pkg::SLOTS-1:0]       vld;
  logic                              rd_vld;
  logic [rbsim_pkg::SLOT_W-1:0]      rd_addr;
  logic [rbsim_pkg::ENTRY_W-1:0]     rd_data;
  logic [rbsim_pkg::ENTRY_W-1:0]     entry;
  logic [3:0]                        rd_op;
  logic                              in_fire;
  logic                              exec_go;
  logic                              ram_we;
  rbsim_pkg::step_out_t              res;

  assign in_fire = in_valid && in_ready;
  assign ram_we  = exec_go && res.wr_en;

  always_comb begin
    state_next = state;
    unique case (state)
      rbsim_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_next = rbsim_pkg::FSM_EXEC;
        end
      end
      rbsim_pkg::FSM_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = rbsim_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = rbsim_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    unique case (state)
      rbsim_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
      end
      rbsim_pkg::FSM_EXEC: begin
        exec_go = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbsim_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q   <= opcode;
      gen_q  <= generation;
      slot_q <= slot_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= rbsim_pkg::CAP_RESET;
      last_gen  <= rbsim_pkg::LGEN_RESET;
      last_cidx <= rbsim_pkg::LCI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbsim_pkg::REG_CAPACITY:  capacity  <= cfg_data[rbsim_pkg::CAP_W-1:0];
        rbsim_pkg::REG_LAST_GEN:  last_gen  <= cfg_data[rbsim_pkg::GEN_BITS-1:0];
        rbsim_pkg::REG_LAST_CIDX: last_cidx <= cfg_data[rbsim_pkg::POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign rd_op   = (state == rbsim_pkg::FSM_IDLE) ? opcode : op_q;
  assign rd_addr = (rd_op == rbsim_pkg::OP_RSV_PUSH) ? push.slot : pop.slot;

  rbsim_ram #(
    .WIDTH (rbsim_pkg::ENTRY_W),
    .DEPTH (rbsim_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (res.wr_addr),
    .wdata (res.wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (ram_we) begin
        vld[res.wr_addr] <= 1'b1;
      end
    end
  end

  assign entry = rd_vld ? rd_data : '0;

  rbsim_step u_step (
    .op        (op_q),
    .gen_in    (gen_q),
    .slot_in   (slot_q),
    .entry     (entry),
    .push      (push),
    .pop       (pop),
    .disabled  (disabled),
    .capacity  (capacity),
    .last_gen  (last_gen),
    .last_cidx (last_cidx),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      push     <= '0;
      pop      <= '0;
      disabled <= 1'b0;
    end else if (exec_go) begin
      push     <= res.push_next;
      pop      <= res.pop_next;
      disabled <= res.disabled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status             <= res.status;
      granted_generation <= res.ggen;
      granted_slot       <= res.gslot;
      queue_length       <= res.qlen;
      enabled            <= !res.disabled_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A second transaction was accepted while one was in progress.");

  a_grant_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rbsim_pkg::STAT_OK |->
      granted_generation == '0 && granted_slot == '0)
    else $error("A grant was reported with a non-ok status.");

  a_disabled_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rbsim_pkg::STAT_DISABLED |-> !enabled)
    else $error("A disabled status was reported while enabled.");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == rbsim_pkg::FSM_EXEC && $past(state) == rbsim_pkg::FSM_IDLE ||
               ram_we && state == rbsim_pkg::FSM_EXEC && $past(state) == rbsim_pkg::FSM_EXEC)
    else $error("Slot table written outside the update cycle.");
`endif

endmodule

`default_nettype wire

// ===== src/rbsim_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
`default_nettype none

module rbsim_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rbsim_step.sv =====
// Update logic for one transaction: decides status, slot write-back, new positions and length.
// Depends on rbsim_pkg.
`default_nettype none

module rbsim_step (
  input  wire logic [3:0]                     op,
  input  wire logic [rbsim_pkg::GEN_BITS-1:0] gen_in,
  input  wire logic [rbsim_pkg::SLOT_W-1:0]   slot_in,
  input  wire logic [rbsim_pkg::ENTRY_W-1:0]  entry,
  input  wire rbsim_pkg::pos_t                push,
  input  wire rbsim_pkg::pos_t                pop,
  input  wire logic                           disabled,
  input  wire logic [rbsim_pkg::CAP_W-1:0]    capacity,
  input  wire logic [rbsim_pkg::GEN_BITS-1:0] last_gen,
  input  wire logic [rbsim_pkg::POS_W-1:0]    last_cidx,
  output rbsim_pkg::step_out_t                res
);

  localparam int GB = rbsim_pkg::GEN_BITS;
  localparam int SW = rbsim_pkg::SLOT_W;
  localparam int PW = rbsim_pkg::POS_W;
  localparam int CW = rbsim_pkg::CAP_W;
  localparam int DW = PW + 2;

  function automatic logic [GB-1:0] next_gen(input logic [GB-1:0] g,
                                             input logic [GB-1:0] lg);
    logic [GB-1:0] r;
    if (g == lg) begin
      r = '0;
    end else begin
      r = g + GB'(1);
    end
    return r;
  endfunction

  function automatic rbsim_pkg::pos_t advance(input rbsim_pkg::pos_t p,
                                              input logic [CW-1:0] cap,
                                              input logic [GB-1:0] lg,
                                              input logic [PW-1:0] lci);
    rbsim_pkg::pos_t r;
    logic [SW:0] s1;
    s1 = {1'b0, p.slot} + (SW+1)'(1);
    r = p;
    if (p.pos == lci) begin
      r = '0;
    end else begin
      r.pos = p.pos + PW'(1);
      if (CW'(s1) >= cap) begin
        r.slot = '0;
        r.gen  = next_gen(p.gen, lg);
      end else begin
        r.slot = s1[SW-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic one_behind(input logic [GB-1:0] cur,
                                      input logic [GB-1:0] eg,
                                      input logic [GB-1:0] lg);
    return ({1'b0, cur} == ({1'b0, eg} + (GB+1)'(1))) ||
           ({1'b0, eg} == ({1'b0, cur} + {1'b0, lg}));
  endfunction

  function automatic logic [rbsim_pkg::LEN_W-1:0] length_of(input logic [PW-1:0] pu,
                                                            input logic [PW-1:0] po,
                                                            input logic [CW-1:0] cap,
                                                            input logic [PW-1:0] lci);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] d2;
    logic signed [DW-1:0] capv;
    logic signed [DW-1:0] halfv;
    logic signed [DW-1:0] r;
    d     = $signed({2'b00, pu}) - $signed({2'b00, po});
    capv  = $signed({{(DW-CW){1'b0}}, cap});
    halfv = $signed({3'b000, lci[PW-1:1]});
    d2    = d + $signed({2'b00, lci}) + DW'(1);
    r     = '0;
    if (!d[DW-1]) begin
      r = (d > capv) ? '0 : d;
    end else if (d < -halfv) begin
      if (d2 > capv) begin
        r = capv;
      end else if (d2[DW-1]) begin
        r = '0;
      end else begin
        r = d2;
      end
    end
    return r[rbsim_pkg::LEN_W-1:0];
  endfunction

  logic [CW-1:0]      cap_eff;
  logic [GB-1:0]      eg;
  logic [1:0]         es;
  logic               s_in_range;
  logic [PW:0]        clr_idx;
  rbsim_pkg::pos_t    push_adv;
  rbsim_pkg::pos_t    pop_adv;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (capacity > CW'(rbsim_pkg::SLOTS)) begin
      cap_eff = CW'(rbsim_pkg::SLOTS);
    end else begin
      cap_eff = capacity;
    end
  end

  assign eg         = entry[rbsim_pkg::ENTRY_W-1:rbsim_pkg::ST_W];
  assign es         = entry[rbsim_pkg::ST_W-1:0];
  assign s_in_range = (CW'(slot_in) < cap_eff);
  assign clr_idx    = (PW+1)'(gen_in) * (PW+1)'(cap_eff) + (PW+1)'(slot_in);
  assign push_adv   = advance(push, cap_eff, last_gen, last_cidx);
  assign pop_adv    = advance(pop, cap_eff, last_gen, last_cidx);

  always_comb begin
    res               = '0;
    res.wr_addr       = slot_in;
    res.push_next     = push;
    res.pop_next      = pop;
    res.disabled_next = disabled;
    res.status        = rbsim_pkg::STAT_OK;
    unique case (op)
      rbsim_pkg::OP_RSV_PUSH: begin
        if (disabled) begin
          res.status = rbsim_pkg::STAT_DISABLED;
        end else if (eg == push.gen && es == rbsim_pkg::SLOT_EMPTY) begin
          res.wr_en     = 1'b1;
          res.wr_addr   = push.slot;
          res.wr_data   = {push.gen, rbsim_pkg::SLOT_WRITING};
          res.ggen      = push.gen;
          res.gslot     = push.slot;
          res.push_next = push_adv;
        end else if (one_behind(push.gen, eg, last_gen)) begin
          res.status = (es == rbsim_pkg::SLOT_READING) ? rbsim_pkg::STAT_BUSY
                                                       : rbsim_pkg::STAT_FULL;
        end else begin
          res.push_next = push_adv;
          res.status    = rbsim_pkg::STAT_BUSY;
        end
      end
      rbsim_pkg::OP_COMMIT_PUSH: begin
        res.wr_en   = s_in_range;
        res.wr_data = {gen_in, rbsim_pkg::SLOT_FULL};
      end
      rbsim_pkg::OP_RSV_POP: begin
        if (eg == pop.gen && es == rbsim_pkg::SLOT_FULL) begin
          res.wr_en    = 1'b1;
          res.wr_addr  = pop.slot;
          res.wr_data  = {pop.gen, rbsim_pkg::SLOT_READING};
          res.ggen     = pop.gen;
          res.gslot    = pop.slot;
          res.pop_next = pop_adv;
        end else if (one_behind(pop.gen, eg, last_gen)) begin
          res.status = rbsim_pkg::STAT_EMPTY;
        end else if (eg == pop.gen && es == rbsim_pkg::SLOT_EMPTY) begin
          res.status = rbsim_pkg::STAT_EMPTY;
        end else if (eg != pop.gen || es == rbsim_pkg::SLOT_WRITING) begin
          res.status = rbsim_pkg::STAT_BUSY;
        end else begin
          res.pop_next = pop_adv;
          res.status   = rbsim_pkg::STAT_BUSY;
        end
      end
      rbsim_pkg::OP_COMMIT_POP: begin
        res.wr_en   = s_in_range;
        res.wr_data = {next_gen(gen_in, last_gen), rbsim_pkg::SLOT_EMPTY};
      end
      rbsim_pkg::OP_ABORT_PUSH: begin
        res.wr_en   = s_in_range;
        res.wr_data = {next_gen(gen_in, last_gen), rbsim_pkg::SLOT_EMPTY};
        if (s_in_range) begin
          res.pop_next = pop_adv;
        end
      end
      rbsim_pkg::OP_CLEAR_POP: begin
        if (clr_idx == {1'b0, pop.pos}) begin
          res.status = rbsim_pkg::STAT_CLEAR_END;
        end else if (eg == pop.gen && es == rbsim_pkg::SLOT_FULL) begin
          res.wr_en    = 1'b1;
          res.wr_addr  = pop.slot;
          res.wr_data  = {pop.gen, rbsim_pkg::SLOT_READING};
          res.ggen     = pop.gen;
          res.gslot    = pop.slot;
          res.pop_next = pop_adv;
        end else if (es == rbsim_pkg::SLOT_WRITING || es == rbsim_pkg::SLOT_FULL) begin
          res.status = rbsim_pkg::STAT_BUSY;
        end else begin
          res.pop_next = pop_adv;
          res.status   = rbsim_pkg::STAT_BUSY;
        end
      end
      rbsim_pkg::OP_DISABLE: begin
        res.disabled_next = 1'b1;
      end
      rbsim_pkg::OP_ENABLE: begin
        res.disabled_next = 1'b0;
      end
      default: begin
      end
    endcase
    res.qlen = length_of(res.push_next.pos, res.pop_next.pos, cap_eff, last_cidx);
  end

endmodule

`default_nettype wire
